FILE: rtl/segment_sphere_intersect_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment sphere intersection unit
// Concurrent assertion helpers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SPHERE_INTERSECT_UNIT_DEFINES_SVH
`define SEGMENT_SPHERE_INTERSECT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SSI_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
`define SSI_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SSI_ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define SSI_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment sphere intersection package
// Field widths and the internal widths derived from them.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int FRAC_BITS       = 16;
   localparam int RADIUS_WIDTH    = COORD_WIDTH - 1;
   localparam int CSR_WIDTH       = 32;
   localparam int THRESHOLD_RESET = 4295;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 3;
   localparam int MAG_W   = PROD_W + 1;
   localparam int HALF_W  = (MAG_W + 1) / 2;
   localparam int HIGH_W  = MAG_W - HALF_W;
   localparam int WIDE_W  = 2 * MAG_W;
   localparam int DISC_W  = WIDE_W + 3;
   localparam int RAD_W   = WIDE_W + 2 + 2 * FRAC_BITS;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int NB_W    = ROOT_W;
   localparam int NUM_W   = ROOT_W + 2;
   localparam int DEN_W   = MAG_W;
   localparam int QUO_W   = COORD_WIDTH + 1;
   localparam int DIV_LAT = QUO_W + 1;
   localparam int CMP_W   = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   localparam logic [63:0] ROOT_MAX = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;

endpackage

FILE: rtl/ssi_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ssi_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ssi_pkg::RAD_W-1:0]   in_radicand,
   output logic                        out_valid,
   output logic [ssi_pkg::ROOT_W-1:0]  out_root
);

   localparam int REM_W = ssi_pkg::ROOT_W + 2;

   logic                        valid_ff [ssi_pkg::ROOT_W];
   logic [REM_W-1:0]            rem_ff   [ssi_pkg::ROOT_W];
   logic [ssi_pkg::ROOT_W-1:0]  root_ff  [ssi_pkg::ROOT_W];
   logic [ssi_pkg::RAD_W-1:0]   rad_ff   [ssi_pkg::ROOT_W];

   logic                        valid_in [ssi_pkg::ROOT_W];
   logic [REM_W-1:0]            rem_in   [ssi_pkg::ROOT_W];
   logic [ssi_pkg::ROOT_W-1:0]  root_in  [ssi_pkg::ROOT_W];
   logic [ssi_pkg::RAD_W-1:0]   rad_in   [ssi_pkg::ROOT_W];

   always_comb begin
      logic [REM_W-1:0]           src_rem;
      logic [ssi_pkg::ROOT_W-1:0] src_root;
      logic [ssi_pkg::RAD_W-1:0]  src_rad;
      logic                       src_valid;
      logic [REM_W+1:0]           trial_rem;
      logic [REM_W+1:0]           trial;
      logic                       ge;
      for (int s = 0; s < ssi_pkg::ROOT_W; s++) begin
         if (s == 0) begin
            src_valid = in_valid;
            src_rem   = '0;
            src_root  = '0;
            src_rad   = in_radicand;
         end else begin
            src_valid = valid_ff[s-1];
            src_rem   = rem_ff[s-1];
            src_root  = root_ff[s-1];
            src_rad   = rad_ff[s-1];
         end
         trial_rem   = {src_rem, src_rad[ssi_pkg::RAD_W-1:ssi_pkg::RAD_W-2]};
         trial       = (REM_W+2)'({src_root, 2'b01});
         ge          = trial_rem >= trial;
         valid_in[s] = src_valid;
         rem_in[s]   = ge ? REM_W'(trial_rem - trial) : REM_W'(trial_rem);
         root_in[s]  = {src_root[ssi_pkg::ROOT_W-2:0], ge};
         rad_in[s]   = src_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ssi_pkg::ROOT_W; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
      end
   end

   assign out_valid = valid_ff[ssi_pkg::ROOT_W-1];
   assign out_root  = root_ff[ssi_pkg::ROOT_W-1];

endmodule

FILE: rtl/ssi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned floor quotient of limited width with an overflow flag, one
// quotient bit per register stage after an overflow check stage.
// ----------------------------------------------------------------------------
module ssi_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [ssi_pkg::NUM_W-1:0]  in_num,
   input  logic [ssi_pkg::DEN_W-1:0]  in_den,
   output logic                       out_valid,
   output logic [ssi_pkg::QUO_W-1:0]  out_quot,
   output logic                       out_ovf
);

   localparam int DEPTH = ssi_pkg::DIV_LAT;

   logic                       valid_ff [DEPTH];
   logic                       ovf_ff   [DEPTH];
   logic [ssi_pkg::DEN_W-1:0]  den_ff   [DEPTH];
   logic [ssi_pkg::DEN_W-1:0]  rem_ff   [DEPTH];
   logic [ssi_pkg::QUO_W-1:0]  low_ff   [DEPTH];
   logic [ssi_pkg::QUO_W-1:0]  quot_ff  [DEPTH];

   logic                       ovf_in;
   logic [ssi_pkg::DEN_W-1:0]  rem_in   [DEPTH];
   logic [ssi_pkg::QUO_W-1:0]  quot_in  [DEPTH];

   assign ovf_in = ssi_pkg::CMP_W'(in_num) >= (ssi_pkg::CMP_W'(in_den) << ssi_pkg::QUO_W);

   always_comb begin
      logic [ssi_pkg::DEN_W:0] trial_rem;
      logic                    ge;
      rem_in[0]  = ssi_pkg::DEN_W'(in_num >> ssi_pkg::QUO_W);
      quot_in[0] = '0;
      for (int j = 1; j < DEPTH; j++) begin
         trial_rem  = {rem_ff[j-1], low_ff[j-1][ssi_pkg::QUO_W-1]};
         ge         = trial_rem >= {1'b0, den_ff[j-1]};
         rem_in[j]  = ge ? ssi_pkg::DEN_W'(trial_rem - {1'b0, den_ff[j-1]})
                         : ssi_pkg::DEN_W'(trial_rem);
         quot_in[j] = {quot_ff[j-1][ssi_pkg::QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j < DEPTH; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff[0]  <= ovf_in;
      den_ff[0]  <= in_den;
      low_ff[0]  <= in_num[ssi_pkg::QUO_W-1:0];
      rem_ff[0]  <= rem_in[0];
      quot_ff[0] <= quot_in[0];
      for (int j = 1; j < DEPTH; j++) begin
         ovf_ff[j]  <= ovf_ff[j-1];
         den_ff[j]  <= den_ff[j-1];
         low_ff[j]  <= low_ff[j-1] << 1;
         rem_ff[j]  <= rem_in[j];
         quot_ff[j] <= quot_in[j];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_quot  = quot_ff[DEPTH-1];
   assign out_ovf   = ovf_ff[DEPTH-1];

endmodule

FILE: rtl/segment_sphere_intersect_unit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; busy stays low.
// The pipeline is made of the square root pipeline (84 stages, one root bit each),
// the two parallel dividers (34 stages each) and nine arithmetic and output stages.
// Reset clears all valid bits and loads the threshold register with 4295.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Segment sphere intersection unit
// Forms the line/sphere quadratic, tests it and returns both roots.
// ----------------------------------------------------------------------------
`include "segment_sphere_intersect_unit_defines.svh"
module segment_sphere_intersect_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_start_x,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_start_y,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_start_z,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_end_x,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_end_y,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_end_z,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_center_x,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_center_y,
   input  logic signed [ssi_pkg::COORD_WIDTH-1:0]  req_center_z,
   input  logic        [ssi_pkg::RADIUS_WIDTH-1:0] req_radius,
   output logic                                    rsp_valid,
   output logic                                    rsp_hit,
   output logic signed [ssi_pkg::COORD_WIDTH-1:0]  rsp_root_plus,
   output logic signed [ssi_pkg::COORD_WIDTH-1:0]  rsp_root_minus,
   input  logic                                    csr_wr_en,
   input  logic        [ssi_pkg::CSR_WIDTH-1:0]    csr_wr_data
);

   localparam int C = ssi_pkg::COORD_WIDTH;

   typedef struct packed {
      logic signed [ssi_pkg::NB_W-1:0] nb;
      logic [ssi_pkg::DEN_W-1:0]       two_a;
      logic                            miss;
   } sq_side_type;

   typedef struct packed {
      logic neg_p;
      logic neg_m;
      logic miss;
   } div_side_type;

   function automatic logic [C-1:0] sat_root(input logic neg, input logic ovf,
                                             input logic [ssi_pkg::QUO_W-1:0] q);
      logic [ssi_pkg::QUO_W-1:0] neg_q;
      logic [C-1:0]              r;
      neg_q = -q;
      if (!neg) begin
         r = (ovf || q > ssi_pkg::QUO_W'(ssi_pkg::ROOT_MAX)) ? C'(ssi_pkg::ROOT_MAX) : q[C-1:0];
      end else begin
         r = (ovf || q > ssi_pkg::QUO_W'(ssi_pkg::ROOT_MAX + 64'd1))
             ? {1'b1, {(C-1){1'b0}}} : neg_q[C-1:0];
      end
      return r;
   endfunction

   logic signed [C-1:0] p1 [3];
   logic signed [C-1:0] p2 [3];
   logic signed [C-1:0] ctr [3];

   assign p1[0]  = req_start_x;
   assign p1[1]  = req_start_y;
   assign p1[2]  = req_start_z;
   assign p2[0]  = req_end_x;
   assign p2[1]  = req_end_y;
   assign p2[2]  = req_end_z;
   assign ctr[0] = req_center_x;
   assign ctr[1] = req_center_y;
   assign ctr[2] = req_center_z;

   assign busy = 1'b0;

   logic [ssi_pkg::CSR_WIDTH-1:0] thr_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vn1_ff, vn2_ff;
   logic rsp_valid_ff, rsp_hit_ff;
   logic [C-1:0] rsp_root_plus_ff, rsp_root_minus_ff;

   logic signed [ssi_pkg::DIFF_W-1:0] d1_ff [3];
   logic signed [ssi_pkg::DIFF_W-1:0] l1_ff [3];
   logic [ssi_pkg::RADIUS_WIDTH-1:0]  r1_ff;

   logic signed [ssi_pkg::PROD_W-1:0] dd2_ff [3];
   logic signed [ssi_pkg::PROD_W-1:0] dl2_ff [3];
   logic signed [ssi_pkg::PROD_W-1:0] ll2_ff [3];
   logic [2*ssi_pkg::RADIUS_WIDTH-1:0] rr2_ff;

   logic signed [ssi_pkg::SUM_W-1:0] a3_ff, b3_ff, c3_ff;
   logic signed [ssi_pkg::SUM_W-1:0] a3_in, b3_in, c3_in, dl_sum, ll_sum;

   logic [2*ssi_pkg::HALF_W-1:0] bll4_ff, all4_ff;
   logic [ssi_pkg::MAG_W-1:0]    blh4_ff, alh4_ff, ahl4_ff;
   logic [2*ssi_pkg::HIGH_W-1:0] bhh4_ff, ahh4_ff;
   logic                         deg4_ff, c_neg4_ff;
   logic [ssi_pkg::DEN_W-1:0]    two_a4_ff;
   logic signed [ssi_pkg::NB_W-1:0] nb4_ff;

   logic [ssi_pkg::SUM_W-1:0] b_abs, c_abs;
   logic [ssi_pkg::MAG_W-1:0] a_mag, b_mag, c_mag;
   logic signed [ssi_pkg::NB_W-1:0] nb4_in;

   logic [ssi_pkg::WIDE_W-1:0]      b2_5_ff, ac5_ff, b2_5_in, ac5_in;
   logic                            deg5_ff, c_neg5_ff;
   logic [ssi_pkg::DEN_W-1:0]       two_a5_ff;
   logic signed [ssi_pkg::NB_W-1:0] nb5_ff;

   logic signed [ssi_pkg::DISC_W-1:0] disc6_ff, disc6_in;
   logic [ssi_pkg::DISC_W-1:0]        b2x, fac;
   logic                              miss6_ff;
   logic [ssi_pkg::DEN_W-1:0]         two_a6_ff;
   logic signed [ssi_pkg::NB_W-1:0]   nb6_ff;

   logic [ssi_pkg::RAD_W-1:0]  radicand;
   logic                       sq_valid;
   logic [ssi_pkg::ROOT_W-1:0] sq_root;
   sq_side_type                sq_side_ff [ssi_pkg::ROOT_W];
   sq_side_type                sq_out;

   logic [ssi_pkg::NUM_W-1:0] n1_p_ff, n1_m_ff;
   logic [ssi_pkg::DEN_W-1:0] two_a_n1_ff, two_a_n2_ff;
   logic                      miss_n1_ff, miss_n2_ff;
   logic [ssi_pkg::NUM_W-1:0] m2_p_ff, m2_m_ff;
   logic                      neg2_p_ff, neg2_m_ff;

   logic                      div_p_valid, div_m_valid, div_p_ovf, div_m_ovf;
   logic [ssi_pkg::QUO_W-1:0] div_p_quot, div_m_quot;
   div_side_type              div_side_ff [ssi_pkg::DIV_LAT];
   div_side_type              div_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= ssi_pkg::CSR_WIDTH'(ssi_pkg::THRESHOLD_RESET);
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         vn1_ff       <= 1'b0;
         vn2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         v1_ff        <= start & ~busy;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         vn1_ff       <= sq_valid;
         vn2_ff       <= vn1_ff;
         rsp_valid_ff <= div_p_valid;
      end
   end

   always_comb begin
      a3_in  = ssi_pkg::SUM_W'(dd2_ff[0]) + ssi_pkg::SUM_W'(dd2_ff[1])
             + ssi_pkg::SUM_W'(dd2_ff[2]);
      dl_sum = ssi_pkg::SUM_W'(dl2_ff[0]) + ssi_pkg::SUM_W'(dl2_ff[1])
             + ssi_pkg::SUM_W'(dl2_ff[2]);
      ll_sum = ssi_pkg::SUM_W'(ll2_ff[0]) + ssi_pkg::SUM_W'(ll2_ff[1])
             + ssi_pkg::SUM_W'(ll2_ff[2]);
      b3_in  = dl_sum <<< 1;
      c3_in  = ll_sum - ssi_pkg::SUM_W'(rr2_ff);
   end

   always_comb begin
      a_mag  = a3_ff[ssi_pkg::MAG_W-1:0];
      b_abs  = b3_ff[ssi_pkg::SUM_W-1] ? -b3_ff : b3_ff;
      c_abs  = c3_ff[ssi_pkg::SUM_W-1] ? -c3_ff : c3_ff;
      b_mag  = b_abs[ssi_pkg::MAG_W-1:0];
      c_mag  = c_abs[ssi_pkg::MAG_W-1:0];
      nb4_in = -(ssi_pkg::NB_W'(b3_ff) <<< ssi_pkg::FRAC_BITS);
   end

   always_comb begin
      b2_5_in = (ssi_pkg::WIDE_W'(bhh4_ff) << (2*ssi_pkg::HALF_W))
              + (ssi_pkg::WIDE_W'(blh4_ff) << (ssi_pkg::HALF_W+1))
              + ssi_pkg::WIDE_W'(bll4_ff);
      ac5_in  = (ssi_pkg::WIDE_W'(ahh4_ff) << (2*ssi_pkg::HALF_W))
              + ((ssi_pkg::WIDE_W'(alh4_ff) + ssi_pkg::WIDE_W'(ahl4_ff)) << ssi_pkg::HALF_W)
              + ssi_pkg::WIDE_W'(all4_ff);
   end

   always_comb begin
      b2x      = ssi_pkg::DISC_W'(b2_5_ff);
      fac      = ssi_pkg::DISC_W'(ac5_ff) << 2;
      disc6_in = c_neg5_ff ? b2x + fac : b2x - fac;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         d1_ff[k]  <= ssi_pkg::DIFF_W'(p2[k]) - ssi_pkg::DIFF_W'(p1[k]);
         l1_ff[k]  <= ssi_pkg::DIFF_W'(p1[k]) - ssi_pkg::DIFF_W'(ctr[k]);
         dd2_ff[k] <= d1_ff[k] * d1_ff[k];
         dl2_ff[k] <= d1_ff[k] * l1_ff[k];
         ll2_ff[k] <= l1_ff[k] * l1_ff[k];
      end
      r1_ff  <= req_radius;
      rr2_ff <= r1_ff * r1_ff;

      a3_ff <= a3_in;
      b3_ff <= b3_in;
      c3_ff <= c3_in;

      bll4_ff   <= b_mag[ssi_pkg::HALF_W-1:0] * b_mag[ssi_pkg::HALF_W-1:0];
      blh4_ff   <= b_mag[ssi_pkg::HALF_W-1:0] * b_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W];
      bhh4_ff   <= b_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W]
                 * b_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W];
      all4_ff   <= a_mag[ssi_pkg::HALF_W-1:0] * c_mag[ssi_pkg::HALF_W-1:0];
      alh4_ff   <= a_mag[ssi_pkg::HALF_W-1:0] * c_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W];
      ahl4_ff   <= a_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W] * c_mag[ssi_pkg::HALF_W-1:0];
      ahh4_ff   <= a_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W]
                 * c_mag[ssi_pkg::MAG_W-1:ssi_pkg::HALF_W];
      deg4_ff   <= (a3_ff == '0) || ($unsigned(a3_ff) < ssi_pkg::SUM_W'(thr_ff));
      c_neg4_ff <= c3_ff[ssi_pkg::SUM_W-1];
      two_a4_ff <= {a_mag[ssi_pkg::MAG_W-2:0], 1'b0};
      nb4_ff    <= nb4_in;

      b2_5_ff   <= b2_5_in;
      ac5_ff    <= ac5_in;
      deg5_ff   <= deg4_ff;
      c_neg5_ff <= c_neg4_ff;
      two_a5_ff <= two_a4_ff;
      nb5_ff    <= nb4_ff;

      disc6_ff  <= disc6_in;
      miss6_ff  <= deg5_ff || disc6_in[ssi_pkg::DISC_W-1];
      two_a6_ff <= two_a5_ff;
      nb6_ff    <= nb5_ff;
   end

   assign radicand = miss6_ff ? '0
                   : {disc6_ff[ssi_pkg::WIDE_W+1:0], {(2*ssi_pkg::FRAC_BITS){1'b0}}};

   ssi_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v6_ff),
      .in_radicand (radicand),
      .out_valid   (sq_valid),
      .out_root    (sq_root)
   );

   always_ff @(posedge clock) begin
      sq_side_ff[0] <= '{nb: nb6_ff, two_a: two_a6_ff, miss: miss6_ff};
      for (int i = 1; i < ssi_pkg::ROOT_W; i++) begin
         sq_side_ff[i] <= sq_side_ff[i-1];
      end
   end

   assign sq_out = sq_side_ff[ssi_pkg::ROOT_W-1];

   always_ff @(posedge clock) begin
      n1_p_ff     <= ssi_pkg::NUM_W'(sq_out.nb) + ssi_pkg::NUM_W'(sq_root);
      n1_m_ff     <= ssi_pkg::NUM_W'(sq_out.nb) - ssi_pkg::NUM_W'(sq_root);
      two_a_n1_ff <= sq_out.two_a;
      miss_n1_ff  <= sq_out.miss;

      neg2_p_ff   <= n1_p_ff[ssi_pkg::NUM_W-1];
      neg2_m_ff   <= n1_m_ff[ssi_pkg::NUM_W-1];
      m2_p_ff     <= n1_p_ff[ssi_pkg::NUM_W-1] ? ssi_pkg::NUM_W'(two_a_n1_ff) + ~n1_p_ff
                                               : n1_p_ff;
      m2_m_ff     <= n1_m_ff[ssi_pkg::NUM_W-1] ? ssi_pkg::NUM_W'(two_a_n1_ff) + ~n1_m_ff
                                               : n1_m_ff;
      two_a_n2_ff <= two_a_n1_ff;
      miss_n2_ff  <= miss_n1_ff;
   end

   ssi_divider u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vn2_ff),
      .in_num    (m2_p_ff),
      .in_den    (two_a_n2_ff),
      .out_valid (div_p_valid),
      .out_quot  (div_p_quot),
      .out_ovf   (div_p_ovf)
   );

   ssi_divider u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vn2_ff),
      .in_num    (m2_m_ff),
      .in_den    (two_a_n2_ff),
      .out_valid (div_m_valid),
      .out_quot  (div_m_quot),
      .out_ovf   (div_m_ovf)
   );

   always_ff @(posedge clock) begin
      div_side_ff[0] <= '{neg_p: neg2_p_ff, neg_m: neg2_m_ff, miss: miss_n2_ff};
      for (int i = 1; i < ssi_pkg::DIV_LAT; i++) begin
         div_side_ff[i] <= div_side_ff[i-1];
      end
   end

   assign div_out = div_side_ff[ssi_pkg::DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (div_out.miss) begin
         rsp_hit_ff        <= 1'b0;
         rsp_root_plus_ff  <= '0;
         rsp_root_minus_ff <= '0;
      end else begin
         rsp_hit_ff        <= 1'b1;
         rsp_root_plus_ff  <= sat_root(div_out.neg_p, div_p_ovf, div_p_quot);
         rsp_root_minus_ff <= sat_root(div_out.neg_m, div_m_ovf, div_m_quot);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_root_plus  = rsp_root_plus_ff;
   assign rsp_root_minus = rsp_root_minus_ff;

   `SSI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_root_plus == '0 && rsp_root_minus == '0, "Missed word carries nonzero roots.")
   `SSI_ASSERT_IMPLY(a_root_order, clock, reset, rsp_valid && rsp_hit,
      rsp_root_plus >= rsp_root_minus, "Plus root lies below minus root.")
   `SSI_ASSERT_IMPLY(a_sqrt_align, clock, reset, sq_valid && sq_out.miss,
      sq_root == '0, "Square root and its side data are out of step.")
   `SSI_ASSERT_NEVER(a_div_lockstep, clock, reset, div_p_valid != div_m_valid,
      "Dividers are out of step.")

endmodule

FILE: sim/segment_sphere_intersect_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment sphere intersection unit testbench
// Sends line/sphere words under several threshold settings and with random
// gaps, predicts hit and both saturated roots with wide integer arithmetic,
// and compares every returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module segment_sphere_intersect_unit_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 140;
   localparam int RANDOM_PER_SET = 310;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [ssi_pkg::COORD_WIDTH-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
      logic [ssi_pkg::RADIUS_WIDTH-1:0]       rad;
   } segment_type;

   typedef struct {
      logic                                   hit;
      logic signed [ssi_pkg::COORD_WIDTH-1:0] plus, minus;
   } crossing_type;

   typedef struct {
      segment_type  seg;
      bit           known;
      crossing_type res;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] req_start_x = '0, req_start_y = '0;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] req_start_z = '0;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] req_center_x = '0, req_center_y = '0;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] req_center_z = '0;
   logic [ssi_pkg::RADIUS_WIDTH-1:0]       req_radius = '0;
   logic                                   rsp_valid, rsp_hit;
   logic signed [ssi_pkg::COORD_WIDTH-1:0] rsp_root_plus, rsp_root_minus;
   logic                                   csr_wr_en = 1'b0;
   logic [ssi_pkg::CSR_WIDTH-1:0]          csr_wr_data = '0;

   logic [ssi_pkg::CSR_WIDTH-1:0] threshold = ssi_pkg::THRESHOLD_RESET;
   crossing_type                  pending_crossings[$];
   int                            mismatch_count = 0;
   int                            stall_cycles = 0;
   int                            sender_idle_pct = 0;

   segment_sphere_intersect_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z), .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_root_plus(rsp_root_plus), .rsp_root_minus(rsp_root_minus),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic wide_type floor_div(wide_type n, wide_type d);
      wide_type q;
      q = n / d;
      if (n < 0 && (n % d) != 0) q = q - 1;
      return q;
   endfunction

   function automatic logic signed [ssi_pkg::COORD_WIDTH-1:0] saturate_root(wide_type q);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (ssi_pkg::COORD_WIDTH - 1)) - 1;
      lo = -(wide_type'(1) <<< (ssi_pkg::COORD_WIDTH - 1));
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[ssi_pkg::COORD_WIDTH-1:0];
   endfunction

   function automatic wide_type floor_sqrt(wide_type x);
      wide_type r, cand;
      r = 0;
      for (int i = 100; i >= 0; i--) begin
         cand = r | (wide_type'(1) <<< i);
         if (cand * cand <= x) r = cand;
      end
      return r;
   endfunction

   function automatic crossing_type predict_crossing(segment_type g,
                                                     logic [ssi_pkg::CSR_WIDTH-1:0] thr);
      wide_type p1[3], p2[3], sc[3];
      wide_type a, dl, ll, d, l, b, c, rr, disc, s, nb, two_a;
      crossing_type res;
      p1[0] = g.sx; p1[1] = g.sy; p1[2] = g.sz;
      p2[0] = g.ex; p2[1] = g.ey; p2[2] = g.ez;
      sc[0] = g.cx; sc[1] = g.cy; sc[2] = g.cz;
      a = 0; dl = 0; ll = 0;
      for (int k = 0; k < 3; k++) begin
         d = p2[k] - p1[k];
         l = p1[k] - sc[k];
         a = a + d * d;
         dl = dl + d * l;
         ll = ll + l * l;
      end
      rr = $signed({225'b0, g.rad});
      b = dl + dl;
      c = ll - rr * rr;
      disc = b * b - 4 * a * c;
      res.hit = 1'b0; res.plus = '0; res.minus = '0;
      if (a == 0 || a < $signed({224'b0, thr}) || disc < 0) return res;
      s = floor_sqrt(disc <<< (2 * ssi_pkg::FRAC_BITS));
      nb = -(b <<< ssi_pkg::FRAC_BITS);
      two_a = a + a;
      res.hit = 1'b1;
      res.plus = saturate_root(floor_div(nb + s, two_a));
      res.minus = saturate_root(floor_div(nb - s, two_a));
      return res;
   endfunction

   function automatic logic signed [ssi_pkg::COORD_WIDTH-1:0] random_offset(int sh);
      logic signed [ssi_pkg::COORD_WIDTH-1:0] v;
      v = $urandom;
      return v >>> (ssi_pkg::COORD_WIDTH - 1 - sh);
   endfunction

   function automatic segment_type random_segment();
      segment_type g;
      int kind, sh;
      kind = $urandom_range(0, 9);
      sh = $urandom_range(2, 24);
      g.sx = $urandom; g.sy = $urandom; g.sz = $urandom;
      g.rad = ssi_pkg::RADIUS_WIDTH'($urandom);
      if (kind < 2) begin
         g.ex = $urandom; g.ey = $urandom; g.ez = $urandom;
         g.cx = $urandom; g.cy = $urandom; g.cz = $urandom;
      end else begin
         if (kind < 8) begin
            g.sx = random_offset(sh + 4); g.sy = random_offset(sh + 4);
            g.sz = random_offset(sh + 4);
         end
         g.cx = g.sx + random_offset(sh); g.cy = g.sy + random_offset(sh);
         g.cz = g.sz + random_offset(sh);
         g.rad = ssi_pkg::RADIUS_WIDTH'($urandom) >> (ssi_pkg::RADIUS_WIDTH - 1 - sh);
         if (kind == 2) sh = $urandom_range(0, 8);
         g.ex = g.sx + random_offset(sh); g.ey = g.sy + random_offset(sh);
         g.ez = g.sz + random_offset(sh);
      end
      return g;
   endfunction

   function automatic segment_type make_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                                                int cx, int cy, int cz, int rad);
      segment_type g;
      g.sx = sx; g.sy = sy; g.sz = sz;
      g.ex = ex; g.ey = ey; g.ez = ez;
      g.cx = cx; g.cy = cy; g.cz = cz;
      g.rad = ssi_pkg::RADIUS_WIDTH'(rad);
      return g;
   endfunction

   function automatic crossing_type make_crossing(logic hit, int plus, int minus);
      crossing_type r;
      r.hit = hit; r.plus = plus; r.minus = minus;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_segment(segment_type g, bit known, crossing_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_start_x <= g.sx; req_start_y <= g.sy; req_start_z <= g.sz;
      req_end_x <= g.ex; req_end_y <= g.ey; req_end_z <= g.ez;
      req_center_x <= g.cx; req_center_y <= g.cy; req_center_z <= g.cz;
      req_radius <= g.rad;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_crossings.push_back(known ? want : predict_crossing(g, threshold));
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [ssi_pkg::CSR_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold = value;
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid) begin
         if (pending_crossings.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_root_plus !== want.plus)
               report_mismatch("root_plus", rsp_root_plus, want.plus);
            if (rsp_root_minus !== want.minus)
               report_mismatch("root_minus", rsp_root_minus, want.minus);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      vector_type   vectors[$];
      vector_type   v;
      crossing_type miss;
      logic [ssi_pkg::CSR_WIDTH-1:0] settings[4];
      int one;
      one = 32'h10000;
      miss = make_crossing(1'b0, 0, 0);

      // Unit sphere crossed along x from -2 to 2 gives roots 0.75 and 0.25.
      v.known = 1'b1; v.seg = make_segment(-2 * one, 0, 0, 2 * one, 0, 0, 0, 0, 0, one);
      v.res = make_crossing(1'b1, 49152, 16384); vectors.push_back(v);
      // A zero radius sphere on the line is a tangent: both roots are 0.5.
      v.seg = make_segment(-one, 0, 0, one, 0, 0, 0, 0, 0, 0);
      v.res = make_crossing(1'b1, 32768, 32768); vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      v.res = miss; vectors.push_back(v);
      v.seg = make_segment(one, one, one, one, one, one, 0, 0, 0, 32'h7fffffff);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 1, 0, 0, 0, 0, 0, one);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 3 * one, 4 * one, 0, 0, 0, 10 * one, one);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 256, 0, 0, 1000 * one, 0, 0, one);
      v.res = make_crossing(1'b1, 32'h7fffffff, 32'h7fffffff); vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 256, 0, 0, -1000 * one, 0, 0, one);
      v.res = make_crossing(1'b1, 32'h80000000, 32'h80000000); vectors.push_back(v);
      v.known = 1'b0;
      v.seg = make_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h80000000, 32'h80000000, 32'h80000000,
                           0, 0, 0, 32'h7fffffff);
      vectors.push_back(v);
      v.seg = make_segment(32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      vectors.push_back(v);
      v.seg = make_segment(32'h80000000, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 1,
                           32'h80000000, 32'h7fffffff, 0, 32'h7fffffff);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, 33, 33, 33, 0, 0, 0, one);
      vectors.push_back(v);
      v.seg = make_segment(-one, -one, -one, one, one, one, 0, 0, 0, 2 * one);
      vectors.push_back(v);
      v.seg = make_segment(0, 0, 0, one, 0, 0, 5 * one, 3 * one, 0, 3 * one);
      vectors.push_back(v);

      settings[0] = '0;
      settings[1] = 32'hffffffff;
      settings[2] = $urandom_range(1, 1 << 20);
      settings[3] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 23;
      foreach (vectors[i]) send_segment(vectors[i].seg, vectors[i].known, vectors[i].res);
      drain_pipeline();

      for (int p = 0; p < 4; p++) begin
         write_threshold(settings[p]);
         sender_idle_pct = (p == 0) ? 23 : (p == 1) ? 59 : 0;
         // A line with no length is degenerate even with a zero threshold.
         send_segment(make_segment(one, -one, 7, one, -one, 7, 0, 0, 0, one), 1'b1, miss);
         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            if (p == 3 && n == RANDOM_PER_SET / 2) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_crossings.size() != 0) @(posedge clock);
            end
            send_segment(random_segment(), 1'b0, miss);
         end
         drain_pipeline();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
